/* rtl/clwm_pkg.sv */
// Shared types, constants and the luma range expansion for the luma meter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package clwm_pkg;

  // Field and datapath widths
  localparam int LUMA_W    = 8;
  localparam int CFG_W     = 13;
  localparam int WEIGHT_W  = 7;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 25;
  localparam int POS_CMP_W = 14;  // holds any position + 1 up to 8192
  localparam int STEP_W    = 6;   // counts the SUM_W divider steps
  localparam int BLEND_W   = 15;  // 255 * 100 fits
  localparam int CFG_IDX_W = 3;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register reset values
  localparam logic [CFG_W-1:0]    FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0]    FOCUS_LEFT_RST   = 13'd192;
  localparam logic [CFG_W-1:0]    FOCUS_RIGHT_RST  = 13'd448;
  localparam logic [CFG_W-1:0]    FOCUS_TOP_RST    = 13'd240;
  localparam logic [CFG_W-1:0]    FOCUS_BOTTOM_RST = 13'd432;
  localparam logic [WEIGHT_W-1:0] FOCUS_WEIGHT_RST = 7'd80;

  localparam logic [WEIGHT_W-1:0] PERCENT = 7'd100;

  // Division of the blended sum by 100 through a reciprocal; exact for
  // every sum below 2^21/48, far above 255 * 100.
  localparam logic [BLEND_W-1:0] RECIP_100       = 15'd20972;  // ceil(2^21 / 100)
  localparam int                 RECIP_100_SHIFT = 21;

  // Saturation limits
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Limited-range expansion: black level, scale 255/219 by reciprocal
  localparam logic [LUMA_W-1:0] BLACK_LEVEL = 8'd16;
  localparam logic [16:0]       RECIP_219   = 17'd76609;  // ceil(2^24 / 219)
  localparam int                RECIP_SHIFT = 24;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FOCUS_LEFT   = 3'd2,
    REG_FOCUS_RIGHT  = 3'd3,
    REG_FOCUS_TOP    = 3'd4,
    REG_FOCUS_BOTTOM = 3'd5,
    REG_FOCUS_WEIGHT = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0]    frame_width;
    logic [CFG_W-1:0]    frame_height;
    logic [CFG_W-1:0]    focus_left;
    logic [CFG_W-1:0]    focus_right;
    logic [CFG_W-1:0]    focus_top;
    logic [CFG_W-1:0]    focus_bottom;
    logic [WEIGHT_W-1:0] focus_weight;
  } cfg_regs_t;

  // Region totals of a finished frame
  typedef struct packed {
    logic [SUM_W-1:0] focus_sum;
    logic [CNT_W-1:0] focus_count;
    logic [SUM_W-1:0] background_sum;
    logic [CNT_W-1:0] background_count;
  } frame_stats_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // (v-16)*255/219 truncated, clamped to 0..255; the reciprocal is exact
  // for every product below 2^24/155, far above 239*255.
  function automatic logic [LUMA_W-1:0] expand_luma(input logic [LUMA_W-1:0] v);
    logic [15:0] scaled;
    logic [32:0] prod;
    logic [8:0]  q;
    scaled = 16'(v - BLACK_LEVEL) * 16'd255;
    prod   = 33'(scaled) * 33'(RECIP_219);
    q      = prod[RECIP_SHIFT+8:RECIP_SHIFT];
    if (v <= BLACK_LEVEL) begin
      return '0;
    end else if (q[8]) begin
      return {LUMA_W{1'b1}};
    end else begin
      return q[LUMA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/clwm_divider.sv */
// Shared restoring divider: one quotient bit per cycle, SUM_W steps.
// Depends on clwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clwm_divider (
  input  wire                  clk,
  input  wire                  rst_n,
  input  clwm_pkg::div_req_t   req,
  output clwm_pkg::div_rsp_t   rsp
);

  logic [clwm_pkg::CNT_W:0]        rem_r;
  logic [clwm_pkg::SUM_W-1:0]      quo_r;
  logic [clwm_pkg::CNT_W-1:0]      dsr_r;
  logic [clwm_pkg::STEP_W-1:0]     step_r;
  logic                            done_r;

  logic [clwm_pkg::CNT_W:0]        shifted;
  logic [clwm_pkg::CNT_W:0]        diff;
  logic                            fits;

  // One trial subtraction per step
  always_comb begin
    shifted = {rem_r[clwm_pkg::CNT_W-1:0], quo_r[clwm_pkg::SUM_W-1]};
    fits    = shifted >= {1'b0, dsr_r};
    diff    = shifted - {1'b0, dsr_r};
  end

  // Load on start, then shift and subtract until the step count runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
        step_r <= clwm_pkg::STEP_W'(clwm_pkg::SUM_W);
      end else if (step_r != '0) begin
        rem_r  <= fits ? diff : shifted;
        quo_r  <= {quo_r[clwm_pkg::SUM_W-2:0], fits};
        step_r <= step_r - 1'b1;
        done_r <= (step_r == clwm_pkg::STEP_W'(1));
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

/* rtl/clwm_accum.sv */
// Raster position tracking and per-region sum and count accumulation.
// Depends on clwm_pkg; flags the last pixel of a frame and shows its totals.
`timescale 1ns / 1ps
`default_nettype none

module clwm_accum #(
  parameter int MAX_WIDTH  = clwm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = clwm_pkg::MAX_HEIGHT_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          pix_accept,
  input  wire [clwm_pkg::LUMA_W-1:0]   luma_sample,
  input  wire                          start_of_frame,
  input  clwm_pkg::cfg_regs_t          cfg,
  output logic                         frame_end,
  output clwm_pkg::frame_stats_t       stats
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = clwm_pkg::POS_CMP_W;

  logic [CW-1:0]               col_r, col_nxt, col_cur;
  logic [RW-1:0]               row_r, row_nxt, row_cur;
  logic [clwm_pkg::SUM_W-1:0]  fsum_r, bsum_r, fsum_cur, bsum_cur, fsum_nxt, bsum_nxt;
  logic [clwm_pkg::CNT_W-1:0]  fcnt_r, bcnt_r, fcnt_cur, bcnt_cur, fcnt_nxt, bcnt_nxt;

  logic [PW-1:0]               w_eff, h_eff, col_inc, row_inc;
  logic [clwm_pkg::LUMA_W-1:0] pix;
  logic                        in_focus, line_end;
  logic [clwm_pkg::SUM_W:0]    fsum_add, bsum_add;

  // Clamp frame size to 1..MAX
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = PW'(1);
    end else if (PW'(cfg.frame_width) > PW'(MAX_WIDTH)) begin
      w_eff = PW'(MAX_WIDTH);
    end else begin
      w_eff = PW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = PW'(1);
    end else if (PW'(cfg.frame_height) > PW'(MAX_HEIGHT)) begin
      h_eff = PW'(MAX_HEIGHT);
    end else begin
      h_eff = PW'(cfg.frame_height);
    end
  end

  // Start of frame clears everything ahead of this pixel
  always_comb begin
    col_cur  = start_of_frame ? '0 : col_r;
    row_cur  = start_of_frame ? '0 : row_r;
    fsum_cur = start_of_frame ? '0 : fsum_r;
    bsum_cur = start_of_frame ? '0 : bsum_r;
    fcnt_cur = start_of_frame ? '0 : fcnt_r;
    bcnt_cur = start_of_frame ? '0 : bcnt_r;
  end

  // Region test and saturating accumulation
  always_comb begin
    pix      = clwm_pkg::expand_luma(luma_sample);
    in_focus = (PW'(col_cur) >= PW'(cfg.focus_left)) && (PW'(col_cur) < PW'(cfg.focus_right)) &&
               (PW'(row_cur) >= PW'(cfg.focus_top))  && (PW'(row_cur) < PW'(cfg.focus_bottom));
    fsum_add = {1'b0, fsum_cur} + (clwm_pkg::SUM_W+1)'(pix);
    bsum_add = {1'b0, bsum_cur} + (clwm_pkg::SUM_W+1)'(pix);
    fsum_nxt = fsum_cur;
    fcnt_nxt = fcnt_cur;
    bsum_nxt = bsum_cur;
    bcnt_nxt = bcnt_cur;
    if (in_focus) begin
      fsum_nxt = fsum_add[clwm_pkg::SUM_W] ? clwm_pkg::SUM_MAX : fsum_add[clwm_pkg::SUM_W-1:0];
      if (fcnt_cur != clwm_pkg::CNT_MAX) fcnt_nxt = fcnt_cur + 1'b1;
    end else begin
      bsum_nxt = bsum_add[clwm_pkg::SUM_W] ? clwm_pkg::SUM_MAX : bsum_add[clwm_pkg::SUM_W-1:0];
      if (bcnt_cur != clwm_pkg::CNT_MAX) bcnt_nxt = bcnt_cur + 1'b1;
    end
  end

  // Advance position; the frame ends when both line and row run out
  always_comb begin
    col_inc   = PW'(col_cur) + 1'b1;
    row_inc   = PW'(row_cur) + 1'b1;
    line_end  = !(col_inc < w_eff);
    frame_end = line_end && !(row_inc < h_eff);
    col_nxt   = line_end ? '0 : col_inc[CW-1:0];
    row_nxt   = line_end ? row_inc[RW-1:0] : row_cur;
  end

  assign stats.focus_sum        = fsum_nxt;
  assign stats.focus_count      = fcnt_nxt;
  assign stats.background_sum   = bsum_nxt;
  assign stats.background_count = bcnt_nxt;

  // Update on each transfer; clear after the last pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fsum_r <= '0;
      bsum_r <= '0;
      fcnt_r <= '0;
      bcnt_r <= '0;
    end else if (pix_accept) begin
      if (frame_end) begin
        col_r  <= '0;
        row_r  <= '0;
        fsum_r <= '0;
        bsum_r <= '0;
        fcnt_r <= '0;
        bcnt_r <= '0;
      end else begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        fsum_r <= fsum_nxt;
        bsum_r <= bsum_nxt;
        fcnt_r <= fcnt_nxt;
        bcnt_r <= bcnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/center_weighted_luma_meter_core.sv */
// Center-weighted luma meter: one pixel per cycle, one result per frame.
// An ordinary pixel is taken without a stall. The last pixel of a frame holds
// in_tready low for two passes of the shared divider (focus, background
// average), then blend (S_BLEND_F, S_BLEND_B) and scale by 1/100 (S_SCALE);
// a result still waiting in the output register adds the cycles until taken.
// Reset restores register defaults and clears position, sums and counts.
`timescale 1ns / 1ps
`default_nettype none

module center_weighted_luma_meter_core #(
  parameter int MAX_WIDTH  = clwm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = clwm_pkg::MAX_HEIGHT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // Pixel stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [7:0] luma_sample
  input  wire  [0:0]  in_tuser,    // [0] start_of_frame
  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // [7:0] metered_luma
  output logic [1:0]  out_tuser,   // [0] focus_empty, [1] background_empty
  // Register writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_F,
    S_DIV_B,
    S_BLEND_F,
    S_BLEND_B,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t                             state_r;
  clwm_pkg::cfg_regs_t                cfg_r;
  clwm_pkg::frame_stats_t             stats, stats_r;
  clwm_pkg::div_req_t                 div_req;
  clwm_pkg::div_rsp_t                 div_rsp;
  logic                               div_start_r;
  logic [clwm_pkg::SUM_W-1:0]         div_dividend_r;
  logic [clwm_pkg::CNT_W-1:0]         div_divisor_r;
  logic [clwm_pkg::LUMA_W-1:0]        favg_r, bavg_r, res_r;
  logic [clwm_pkg::BLEND_W-1:0]       acc_r, blend_sum;
  logic [2*clwm_pkg::BLEND_W-1:0]     scale_prod;
  logic                               out_tvalid_r;
  logic [7:0]                         out_tdata_r;
  logic [1:0]                         out_tuser_r;
  logic                               frame_end, in_xfer, fempty, bempty;
  logic [clwm_pkg::WEIGHT_W-1:0]      wt, mul_b;
  logic [clwm_pkg::LUMA_W-1:0]        mul_a;
  logic [clwm_pkg::BLEND_W-1:0]       prod;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  clwm_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_accept     (in_xfer),
    .luma_sample    (in_tdata),
    .start_of_frame (in_tuser[0]),
    .cfg            (cfg_r),
    .frame_end      (frame_end),
    .stats          (stats)
  );

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dividend_r;
  assign div_req.divisor  = div_divisor_r;

  clwm_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Weighting: one small multiplier, used once per region
  always_comb begin
    wt         = (cfg_r.focus_weight > clwm_pkg::PERCENT) ? clwm_pkg::PERCENT
                                                          : cfg_r.focus_weight;
    mul_a      = (state_r == S_BLEND_F) ? favg_r : bavg_r;
    mul_b      = (state_r == S_BLEND_F) ? wt : clwm_pkg::PERCENT - wt;
    prod       = clwm_pkg::BLEND_W'(mul_a) * clwm_pkg::BLEND_W'(mul_b);
    blend_sum  = acc_r + prod;
    scale_prod = (2*clwm_pkg::BLEND_W)'(acc_r) * (2*clwm_pkg::BLEND_W)'(clwm_pkg::RECIP_100);
    fempty     = (stats_r.focus_count == '0);
    bempty     = (stats_r.background_count == '0);
  end

  // Sequencer, register file and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      div_start_r        <= 1'b0;
      out_tvalid_r       <= 1'b0;
      cfg_r.frame_width  <= clwm_pkg::FRAME_WIDTH_RST;
      cfg_r.frame_height <= clwm_pkg::FRAME_HEIGHT_RST;
      cfg_r.focus_left   <= clwm_pkg::FOCUS_LEFT_RST;
      cfg_r.focus_right  <= clwm_pkg::FOCUS_RIGHT_RST;
      cfg_r.focus_top    <= clwm_pkg::FOCUS_TOP_RST;
      cfg_r.focus_bottom <= clwm_pkg::FOCUS_BOTTOM_RST;
      cfg_r.focus_weight <= clwm_pkg::FOCUS_WEIGHT_RST;
    end else begin
      div_start_r <= 1'b0;

      // Register write transfer
      if (cfg_valid) begin
        case (cfg_index)
          clwm_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
          clwm_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
          clwm_pkg::REG_FOCUS_LEFT:   cfg_r.focus_left   <= cfg_data;
          clwm_pkg::REG_FOCUS_RIGHT:  cfg_r.focus_right  <= cfg_data;
          clwm_pkg::REG_FOCUS_TOP:    cfg_r.focus_top    <= cfg_data;
          clwm_pkg::REG_FOCUS_BOTTOM: cfg_r.focus_bottom <= cfg_data;
          clwm_pkg::REG_FOCUS_WEIGHT:
            cfg_r.focus_weight <= cfg_data[clwm_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once it has been taken
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_xfer && frame_end) begin
            stats_r        <= stats;
            div_dividend_r <= stats.focus_sum;
            div_divisor_r  <= stats.focus_count;
            div_start_r    <= 1'b1;
            state_r        <= S_DIV_F;
          end
        end
        S_DIV_F: begin
          if (div_rsp.done) begin
            // Averages never exceed 255, so the low byte is the whole quotient
            favg_r         <= fempty ? '0 : div_rsp.quotient[clwm_pkg::LUMA_W-1:0];
            div_dividend_r <= stats_r.background_sum;
            div_divisor_r  <= stats_r.background_count;
            div_start_r    <= 1'b1;
            state_r        <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          if (div_rsp.done) begin
            bavg_r  <= bempty ? '0 : div_rsp.quotient[clwm_pkg::LUMA_W-1:0];
            state_r <= S_BLEND_F;
          end
        end
        S_BLEND_F: begin
          acc_r   <= prod;
          state_r <= S_BLEND_B;
        end
        S_BLEND_B: begin
          acc_r   <= blend_sum;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          // Divide by 100 through the reciprocal
          res_r   <= scale_prod[clwm_pkg::RECIP_100_SHIFT+clwm_pkg::LUMA_W-1:
                                clwm_pkg::RECIP_100_SHIFT];
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the result register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= res_r;
            out_tuser_r  <= {bempty, fempty};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
